// ===== rtl/core/sbt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character-class functions of the byte tokenizer.
// No dependencies.
`default_nettype none
package sbt_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int QUEUE_DEPTH = 8;
   localparam int MAX_PER_BYTE = 3;

   localparam logic [3:0] K_IDENT = 4'd0;
   localparam logic [3:0] K_NUM   = 4'd1;
   localparam logic [3:0] K_STR   = 4'd2;
   localparam logic [3:0] K_CHR   = 4'd3;
   localparam logic [3:0] K_KW    = 4'd4;
   localparam logic [3:0] K_PUNCT = 4'd5;
   localparam logic [3:0] K_EOL   = 4'd6;
   localparam logic [3:0] K_EOF   = 4'd12;
   localparam logic [3:0] K_ERR   = 4'd13;

   typedef enum logic [3:0] {
      M_IDLE, M_NUM, M_WORD, M_STR, M_CHR, M_PUNCT, M_COMMENT, M_DONE, M_ERR
   } mode_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [5:0]  detail;
      logic [15:0] start_offset;
      logic [15:0] end_offset;
      logic        final_res;
   } tok_type;

   // Results of one byte on their way into the queue.
   typedef struct packed {
      logic [1:0] count;
      tok_type    t2;
      tok_type    t1;
      tok_type    t0;
   } wr_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] idx;
   } hit_type;

   function automatic logic num_ch(input logic [7:0] c);
      return (c >= "0" && c <= "9") || c == "." || c == "_";
   endfunction

   function automatic logic letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic word_ch(input logic [7:0] c);
      return letter(c) || (c >= "0" && c <= "9") || c == "_";
   endfunction

   function automatic hit_type single_of(input logic [7:0] c);
      hit_type r;
      r.hit = 1'b1;
      case (c)
         "(": r.idx = 6'd0;   ")": r.idx = 6'd1;   "{": r.idx = 6'd2;
         "}": r.idx = 6'd3;   "[": r.idx = 6'd4;   "]": r.idx = 6'd5;
         "!": r.idx = 6'd15;  "?": r.idx = 6'd16;  "<": r.idx = 6'd23;
         ">": r.idx = 6'd24;  "&": r.idx = 6'd25;  "|": r.idx = 6'd26;
         "~": r.idx = 6'd27;  "=": r.idx = 6'd28;  "+": r.idx = 6'd29;
         "-": r.idx = 6'd30;  "*": r.idx = 6'd31;  "/": r.idx = 6'd32;
         ",": r.idx = 6'd33;  ";": r.idx = 6'd34;  ".": r.idx = 6'd35;
         ":": r.idx = 6'd36;  "#": r.idx = 6'd37;  "%": r.idx = 6'd38;
         "@": r.idx = 6'd39;
         default: begin
            r.hit = 1'b0;
            r.idx = 6'd0;
         end
      endcase
      return r;
   endfunction

   function automatic logic starts_pair(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == ":"
         || c == "&" || c == "|" || c == "<" || c == ">" || c == "!";
   endfunction

   function automatic hit_type pair_of(input logic [7:0] a, input logic [7:0] b);
      hit_type r;
      r.hit = 1'b1;
      case ({a, b})
         {"+", "="}: r.idx = 6'd6;   {"-", "="}: r.idx = 6'd7;
         {"*", "="}: r.idx = 6'd8;   {"/", "="}: r.idx = 6'd9;
         {"-", ">"}: r.idx = 6'd10;  {"=", ">"}: r.idx = 6'd11;
         {":", "="}: r.idx = 6'd12;  {"&", "&"}: r.idx = 6'd13;
         {"|", "|"}: r.idx = 6'd14;  {"<", "<"}: r.idx = 6'd17;
         {">", ">"}: r.idx = 6'd18;  {"=", "="}: r.idx = 6'd19;
         {"!", "="}: r.idx = 6'd20;  {"<", "="}: r.idx = 6'd21;
         {">", "="}: r.idx = 6'd22;
         default: begin
            r.hit = 1'b0;
            r.idx = 6'd0;
         end
      endcase
      return r;
   endfunction

   // Keyword text, first character in the low byte.
   localparam logic [55:0] KW_TXT [10] = '{
      56'h627570, 56'h74656c, 56'h6e66, 56'h657375, 56'h6669,
      56'h65736c65, 56'h726f66, 56'h656c696877, 56'h686374616d,
      56'h6e7275746572
   };
   localparam logic [3:0] KW_LEN [10] = '{
      4'd3, 4'd3, 4'd2, 4'd3, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd6
   };

   function automatic hit_type keyword_of(input logic [55:0] chars,
                                          input logic [3:0] len);
      hit_type r;
      logic [55:0] mask;
      r.hit = 1'b0;
      r.idx = 6'd0;
      for (int k = 9; k >= 0; k--) begin
         mask = ~(56'hFFFFFFFFFFFFFF << (8 * KW_LEN[k]));
         if (len == KW_LEN[k] && (chars & mask) == KW_TXT[k]) begin
            r.hit = 1'b1;
            r.idx = 6'(k);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sbt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for source bytes and tokens.
// No dependencies.
`default_nettype none
interface sbt_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] in_byte;
   modport source (output valid, func, in_byte, input ready);
   modport sink (input valid, func, in_byte, output ready);
endinterface

interface sbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [5:0]  detail;
   logic [15:0] start_offset;
   logic [15:0] end_offset;
   logic        final_res;
   modport source (output valid, token_kind, detail, start_offset, end_offset,
                   final_res, input ready);
   modport sink (input valid, token_kind, detail, start_offset, end_offset,
                 final_res, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/source_byte_tokenizer.sv =====
`timescale 1ns / 1ps
// Top level of the streaming byte tokenizer: scanner front end and token queue.
// Depends on sbt_pkg, sbt_if, sbt_front and sbt_queue.
//
// The tokenizer accepts one source byte (or the end-of-input marker) per
// cycle while input ready is high, and emits tokens carrying kind, detail and
// start and end offsets. The newest token is held back inside the scanner
// until the next token or a newline decides its final kind, so results trail
// the input by one token. A byte may produce up to three results; they enter
// an eight-entry queue in the same cycle and leave it one per transfer. Input
// ready stays high while the queue has room for three more results, so with
// an always-ready output a stream in which bytes yield on average at most one
// result per byte runs at one byte per cycle; the single output port sets the
// limit when results come faster. After the end-of-input or error result every
// further byte returns a copy of that final result.
`default_nettype none
module source_byte_tokenizer import sbt_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   sbt_req_if.sink  req_if,
   sbt_rsp_if.source rsp_if
);

   wr_type  wr;
   tok_type head;
   logic    room;
   logic    take;

   assign req_if.ready = room;
   assign take = req_if.valid && room;

   sbt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .func    (req_if.func),
      .in_byte (req_if.in_byte),
      .wr      (wr)
   );

   sbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .room      (room),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_tok   (head)
   );

   assign rsp_if.token_kind   = head.token_kind;
   assign rsp_if.detail       = head.detail;
   assign rsp_if.start_offset = head.start_offset;
   assign rsp_if.end_offset   = head.end_offset;
   assign rsp_if.final_res    = head.final_res;

endmodule
`default_nettype wire

// ===== rtl/core/sbt_front.sv =====
`timescale 1ns / 1ps
// Scanner: takes one byte per transfer and produces up to three tokens.
// Depends on sbt_pkg.
`default_nettype none
module sbt_front import sbt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic       func,
   input  wire logic [7:0] in_byte,
   output wr_type          wr
);

   logic [OFFSET_BITS-1:0] off_ff, off_in, ps_ff, ps_in;
   mode_type               mode_ff, mode_in;
   logic [7:0]             pch_ff, pch_in;
   logic [55:0]            wch_ff, wch_in;
   logic [3:0]             wlen_ff, wlen_in;
   logic                   hv_ff, hv_in, halt_ff, halt_in;
   tok_type                ht_ff, ht_in;

   tok_type    o0, o1, o2, ta, tb, ts;
   logic [1:0] n;
   logic       va, vb, used, failed;
   hit_type    kw, pr, sg;
   logic [15:0] off16;

   assign off16 = 16'(off_ff);

   always_comb begin
      off_in = off_ff; ps_in = ps_ff; mode_in = mode_ff; pch_in = pch_ff;
      wch_in = wch_ff; wlen_in = wlen_ff; hv_in = hv_ff; halt_in = halt_ff;
      ht_in = ht_ff;
      o0 = '0; o1 = '0; o2 = '0; n = 2'd0;
      ta = '0; tb = '0; va = 1'b0; vb = 1'b0; used = 1'b0; failed = 1'b0;
      kw = keyword_of(wch_ff, wlen_ff);
      pr = pair_of(pch_ff, in_byte);
      sg = single_of(pch_ff);
      ts = '{K_PUNCT, sg.idx, 16'(ps_ff), 16'(ps_ff + 1'b1), 1'b0};

      if (halt_ff) begin
         o0 = '{(mode_ff == M_DONE) ? K_EOF : K_ERR, 6'd0, off16, off16, 1'b1};
         n = 2'd1;
      end else if (func) begin
         case (mode_ff)
            M_NUM: begin
               ta = '{K_NUM, 6'd0, 16'(ps_ff), off16, 1'b0}; va = 1'b1;
            end
            M_WORD: begin
               ta = '{K_IDENT, 6'd0, 16'(ps_ff), off16, 1'b0}; va = 1'b1;
            end
            M_PUNCT: begin
               ta = ts; va = 1'b1;
            end
            M_STR, M_CHR: failed = 1'b1;
            default: ;
         endcase
         if (va && hv_in) begin
            o0 = ht_in; n = 2'd1;
         end
         if (va) begin
            ht_in = ta; hv_in = 1'b1;
         end
         if (hv_in) begin
            if (n == 2'd0) o0 = ht_in; else o1 = ht_in;
            n = n + 2'd1;
         end
         hv_in = 1'b0;
         if (n == 2'd0) o0 = '{failed ? K_ERR : K_EOF, 6'd0, off16, off16, 1'b1};
         else if (n == 2'd1) o1 = '{failed ? K_ERR : K_EOF, 6'd0, off16, off16, 1'b1};
         else o2 = '{failed ? K_ERR : K_EOF, 6'd0, off16, off16, 1'b1};
         n = n + 2'd1;
         halt_in = 1'b1;
         mode_in = failed ? M_ERR : M_DONE;
      end else begin
         case (mode_ff)
            M_NUM: begin
               if (num_ch(in_byte)) used = 1'b1;
               else begin
                  ta = '{K_NUM, 6'd0, 16'(ps_ff), off16, 1'b0}; va = 1'b1;
                  mode_in = M_IDLE;
               end
            end
            M_WORD: begin
               if (word_ch(in_byte)) begin
                  used = 1'b1;
                  if (wlen_ff < 4'd7) begin
                     wch_in[wlen_ff[2:0]*8 +: 8] = in_byte;
                     wlen_in = wlen_ff + 4'd1;
                  end else begin
                     wlen_in = 4'd8;
                  end
               end else begin
                  mode_in = M_IDLE; va = 1'b1;
                  if (in_byte == " " && kw.hit) begin
                     used = 1'b1;
                     ta = '{K_KW, kw.idx, 16'(ps_ff), 16'(ps_ff + OFFSET_BITS'(wlen_ff)),
                            1'b0};
                  end else begin
                     ta = '{K_IDENT, 6'd0, 16'(ps_ff), off16, 1'b0};
                  end
               end
            end
            M_STR, M_CHR: begin
               used = 1'b1;
               if (in_byte == ((mode_ff == M_STR) ? 8'h22 : 8'h27)) begin
                  ta = '{(mode_ff == M_STR) ? K_STR : K_CHR, 6'd0, 16'(ps_ff), off16, 1'b0};
                  va = 1'b1; mode_in = M_IDLE;
               end
            end
            M_COMMENT: begin
               used = 1'b1;
               if (in_byte == 8'h0A) mode_in = M_IDLE;
            end
            M_PUNCT: begin
               used = 1'b1;
               if (pr.hit) begin
                  ta = '{K_PUNCT, pr.idx, 16'(ps_ff), 16'(off_ff + 1'b1), 1'b0};
                  va = 1'b1; mode_in = M_IDLE;
               end else if (pch_ff == "/" && in_byte == "/") begin
                  mode_in = M_COMMENT;
               end else begin
                  ta = ts; va = 1'b1; mode_in = M_IDLE; used = 1'b0;
               end
            end
            default: mode_in = M_IDLE;
         endcase
         if (va) begin
            if (hv_in) begin
               o0 = ht_in; n = 2'd1;
            end
            ht_in = ta; hv_in = 1'b1;
         end
         if (!used) begin
            sg = single_of(in_byte);
            if (in_byte == " " || in_byte == 8'h09 || in_byte == 8'h0D
                || in_byte == 8'h0C) begin
               // Whitespace is skipped.
            end else if (in_byte == 8'h0A) begin
               if (hv_in && ht_in.token_kind < K_EOL)
                  ht_in.token_kind = ht_in.token_kind + K_EOL;
            end else if (num_ch(in_byte)) begin
               mode_in = M_NUM; ps_in = off_ff;
            end else if (in_byte == 8'h22 || in_byte == 8'h27) begin
               mode_in = (in_byte == 8'h22) ? M_STR : M_CHR;
               ps_in = off_ff + 1'b1;
            end else if (letter(in_byte)) begin
               mode_in = M_WORD; ps_in = off_ff;
               wch_in = {48'd0, in_byte}; wlen_in = 4'd1;
            end else if (starts_pair(in_byte)) begin
               mode_in = M_PUNCT; ps_in = off_ff; pch_in = in_byte;
            end else if (sg.hit) begin
               tb = '{K_PUNCT, sg.idx, off16, 16'(off_ff + 1'b1), 1'b0}; vb = 1'b1;
            end else begin
               failed = 1'b1;
            end
         end
         if ((vb || failed) && hv_in) begin
            if (n == 2'd0) o0 = ht_in; else o1 = ht_in;
            n = n + 2'd1;
            hv_in = 1'b0;
         end
         if (vb) begin
            ht_in = tb; hv_in = 1'b1;
         end
         if (failed) begin
            if (n == 2'd0) o0 = '{K_ERR, 6'd0, off16, off16, 1'b1};
            else if (n == 2'd1) o1 = '{K_ERR, 6'd0, off16, off16, 1'b1};
            else o2 = '{K_ERR, 6'd0, off16, off16, 1'b1};
            n = n + 2'd1;
            halt_in = 1'b1; mode_in = M_ERR;
         end else begin
            off_in = off_ff + 1'b1;
         end
      end
   end

   always_comb begin
      wr.count = take ? n : 2'd0;
      wr.t0 = o0;
      wr.t1 = o1;
      wr.t2 = o2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0; ps_ff <= '0; mode_ff <= M_IDLE; pch_ff <= '0;
         wch_ff <= '0; wlen_ff <= '0; hv_ff <= 1'b0; halt_ff <= 1'b0; ht_ff <= '0;
      end else if (take) begin
         off_ff <= off_in; ps_ff <= ps_in; mode_ff <= mode_in; pch_ff <= pch_in;
         wch_ff <= wch_in; wlen_ff <= wlen_in; hv_ff <= hv_in; halt_ff <= halt_in;
         ht_ff <= ht_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/sbt_queue.sv =====
`timescale 1ns / 1ps
// Token queue: takes up to three tokens per cycle, hands out one per transfer.
// Depends on sbt_pkg.
`default_nettype none
module sbt_queue import sbt_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wr_type    wr,
   output logic      room,
   output logic      out_valid,
   input  wire logic out_ready,
   output tok_type   out_tok
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   tok_type         mem [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;
   logic            pop;

   assign out_valid = cnt_ff != '0;
   assign out_tok   = mem[rp_ff];
   assign pop       = out_valid && out_ready;
   assign room      = cnt_ff <= (PW+1)'(QUEUE_DEPTH - MAX_PER_BYTE);

   always_comb begin
      wp_in  = wp_ff + PW'(wr.count);
      rp_in  = rp_ff + PW'(pop);
      cnt_in = cnt_ff + (PW+1)'(wr.count) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr.count > 2'd0) mem[wp_ff] <= wr.t0;
      if (wr.count > 2'd1) mem[wp_ff + PW'(1)] <= wr.t1;
      if (wr.count > 2'd2) mem[wp_ff + PW'(2)] <= wr.t2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/sbt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the tokenizer, bound to the top level.
// Depends on sbt_pkg and source_byte_tokenizer.
`default_nettype none
module sbt_checker import sbt_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  token_kind,
   input wire logic [5:0]  detail,
   input wire logic [15:0] start_offset,
   input wire logic [15:0] end_offset,
   input wire logic        final_res
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped without transfer");

   a_final_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (token_kind == K_EOF || token_kind == K_ERR) |-> final_res)
      else $error("end result without final flag");

   a_final_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && final_res |-> detail == 6'd0 && start_offset == end_offset)
      else $error("final result with detail or span");

endmodule

bind source_byte_tokenizer sbt_checker u_sbt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .token_kind   (rsp_if.token_kind),
   .detail       (rsp_if.detail),
   .start_offset (rsp_if.start_offset),
   .end_offset   (rsp_if.end_offset),
   .final_res    (rsp_if.final_res)
);
`default_nettype wire
